// ===== rtl/eobr_pkg.sv =====
package eobr_pkg;

	// Field widths of the stream payloads.
	localparam int IDX_W  = 20;
	localparam int SIZE_W = 32;
	localparam int OFF_W  = 48;
	localparam int LEN_W  = 32;
	localparam int ST_W   = 2;

	// Packed stream widths, padded to whole bytes.
	localparam int S_DATA_W = 160;
	localparam int M_DATA_W = 88;

	// Defaults for the top-level parameters.
	localparam int DEF_RANGES  = 16;
	localparam int DEF_MAX_RUN = 64;

	// Input operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_BOUNDS  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOCOVER = 2'd2;
	localparam logic [ST_W-1:0] ST_TOOLONG = 2'd3;

	// Configuration port: 64-bit registers at 8-byte spacing.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CNT_REG_W  = 5;
	localparam logic REG_FSIZE       = 1'b0;
	localparam logic REG_RANGE_COUNT = 1'b1;

	// One range table entry.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  last;
		logic [IDX_W-1:0]  first;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

endpackage

// ===== rtl/eobr_ram.sv =====
module eobr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/eobr_div.sv =====
module eobr_div
	import eobr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OFF_W-1:0]  dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [IDX_W-1:0]  quot,
	output logic [SIZE_W-1:0] rmd
);

	// The quotient is known to fit in IDX_W bits, so the shifted divisor
	// starts at divisor << (IDX_W - 1).
	localparam int DW     = SIZE_W + IDX_W;
	localparam int STEP_W = $clog2(IDX_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dsh_q;
	logic [IDX_W-1:0]  quot_q;
	logic              ge_c;

	assign ge_c = rem_q >= dsh_q;

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= DW'(dividend);
				dsh_q  <= {1'b0, divisor, {(IDX_W - 1){1'b0}}};
			end else if (busy_q) begin
				if (ge_c) begin
					rem_q <= rem_q - dsh_q;
				end
				quot_q <= {quot_q[IDX_W-2:0], ge_c};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rmd  = rem_q[SIZE_W-1:0];

endmodule

// ===== rtl/extent_offset_to_block_run.sv =====
// Block-run locator over a table of block ranges.
// Input stream: s_axis_tuser is the op. A load (op 0) writes one range entry
// into the table and finishes in the cycle it is accepted. A query (op 1)
// gives a byte offset and a length; the block answers on the output stream
// with one transfer per block of the run (status in m_axis_tuser, the last
// block marked by m_axis_tlast), or with a single error transfer.
// The APB port holds the file length at address 0 and the range count at
// address 8; write them only while no query is in flight.
// A query runs the bounds check (S_CHECK), a search that reads, multiplies
// and compares each range in turn (S_WRD, S_WMUL, S_WCMP), the shared
// divider that splits the offset inside the start range, and then two walks
// over the run: one that counts and checks it, one that sends it. Each walk
// steps through the blocks and reads in each range entered after the start
// range (S_NRD, S_NLD); the sending walk first reloads the start range
// (S_RRD, S_RLD). s_axis_tready is high only while no query is active.
// A stalled receiver holds the output register and pauses the sending walk.
// Reset clears the config registers, the control state and the output valid
// flag; the range table itself is not cleared and must be loaded before use.
module extent_offset_to_block_run
	import eobr_pkg::*;
#(
	parameter int RANGES  = DEF_RANGES,
	parameter int MAX_RUN = DEF_MAX_RUN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: range_slot[3:0], first_index[23:4], last_index[43:24],
	// block_bytes[75:44], byte_offset[123:76], byte_length[155:124], zero pad.
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	// tuser: op[0].
	input  logic                  s_axis_tuser,
	// Output stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: block_index[19:0], block_size[51:20], start_offset[83:52], zero pad.
	output logic [M_DATA_W-1:0]   m_axis_tdata,
	// tuser: status[1:0].
	output logic [ST_W-1:0]       m_axis_tuser,
	output logic                  m_axis_tlast,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW     = (RANGES > 1) ? $clog2(RANGES) : 1;
	localparam int CW     = $clog2(RANGES + 1);
	localparam int NW     = $clog2(MAX_RUN + 1);
	localparam int PW     = SIZE_W + NW;
	localparam int BLK_W  = IDX_W + 1;
	localparam int PROD_W = BLK_W + SIZE_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_WRD, S_WMUL, S_WCMP, S_DIV,
		S_RUN, S_NRD, S_NLD, S_RRD, S_RLD, S_ERR
	} state_t;

	state_t            state_q;
	logic [OFF_W-1:0]  fsize_q;
	logic [CNT_REG_W-1:0] range_count_q;

	logic [OFF_W-1:0]  off_q;
	logic [LEN_W-1:0]  len_q;
	logic [OFF_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod_q;
	logic [CW-1:0]     r_q;
	logic [CW-1:0]     found_q;
	logic [IDX_W-1:0]  ent_first_q;
	logic [IDX_W-1:0]  ent_last_q;
	logic [SIZE_W-1:0] ent_size_q;
	logic [IDX_W-1:0]  start_idx_q;
	logic [SIZE_W-1:0] soff_q;
	logic [IDX_W-1:0]  i_q;
	logic [NW-1:0]     n_q;
	logic [PW-1:0]     prc_q;
	logic              emit_q;
	logic [ST_W-1:0]   err_q;

	logic              m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [ST_W-1:0]   m_user_q;
	logic              m_last_q;

	// Input field views.
	logic [3:0]        in_slot;
	entry_t            in_ent;
	logic [OFF_W-1:0]  in_off;
	logic [LEN_W-1:0]  in_len;

	assign in_slot       = s_axis_tdata[3:0];
	assign in_ent.first  = s_axis_tdata[23:4];
	assign in_ent.last   = s_axis_tdata[43:24];
	assign in_ent.size   = s_axis_tdata[75:44];
	assign in_off        = s_axis_tdata[123:76];
	assign in_len        = s_axis_tdata[155:124];

	// Handshakes.
	logic in_xfer;
	logic out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Range table.
	logic              ram_we;
	logic [8:0]        slot_ext;
	logic [AW-1:0]     ram_waddr;
	logic [ENT_W-1:0]  ram_rdata;
	entry_t            rd_ent;

	assign slot_ext  = 9'(in_slot);
	assign ram_waddr = slot_ext[AW-1:0];
	assign ram_we    = in_xfer && (s_axis_tuser == OP_LOAD) && (32'(in_slot) < RANGES);
	assign rd_ent    = entry_t'(ram_rdata);

	eobr_ram #(
		.WIDTH  (ENT_W),
		.DEPTH  (RANGES),
		.ADDR_W (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ENT_W'(in_ent)),
		.raddr (r_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Number of valid entries, clamped to the table depth.
	logic [CW-1:0] cnt_c;
	logic          last_range_c;

	assign cnt_c = (32'(range_count_q) > RANGES) ? CW'(RANGES) : CW'(range_count_q);
	assign last_range_c = ({1'b0, r_q} + (CW + 1)'(1)) >= {1'b0, cnt_c};

	// Size of the range just read: block count times block size.
	logic [BLK_W-1:0]  blocks_c;
	logic [PROD_W-1:0] prod_c;
	logic              skip_c;

	assign blocks_c = (rd_ent.last < rd_ent.first) ? '0 :
		({1'b0, rd_ent.last} - {1'b0, rd_ent.first} + BLK_W'(1));
	assign prod_c   = PROD_W'(blocks_c) * PROD_W'(rd_ent.size);
	assign skip_c   = rd_ent.last < rd_ent.first;

	// Search compare and bounds check.
	logic              rem_ge_c;
	logic              oob_c;

	assign rem_ge_c = PROD_W'(rem_q) >= prod_q;
	assign oob_c    = (off_q >= fsize_q) ||
		(({1'b0, off_q} + (OFF_W + 1)'(len_q)) > {1'b0, fsize_q});

	// Shared divider for the start block and the offset inside it.
	logic              div_start;
	logic              div_done;
	logic [IDX_W-1:0]  div_quot;
	logic [SIZE_W-1:0] div_rmd;

	assign div_start = (state_q == S_WCMP) && !rem_ge_c;

	eobr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_q),
		.divisor  (ent_size_q),
		.done     (div_done),
		.quot     (div_quot),
		.rmd      (div_rmd)
	);

	// Per-block step of the run walk.
	logic              first_c;
	logic [SIZE_W-1:0] add_c;
	logic [PW-1:0]     prc_nxt_c;
	logic              covered_c;
	logic              step_c;
	logic              full_c;
	logic              out_load_c;

	assign first_c   = (n_q == '0);
	assign add_c     = first_c ? (ent_size_q - soff_q) : ent_size_q;
	assign prc_nxt_c = prc_q + PW'(add_c);
	assign covered_c = prc_nxt_c >= PW'(len_q);
	assign step_c    = !emit_q || out_free;
	assign full_c    = 32'(n_q) >= MAX_RUN;

	// The output register takes a block of the sending walk or an error.
	assign out_load_c = out_free &&
		(((state_q == S_RUN) && emit_q && !full_c) || (state_q == S_ERR));

	// Sequencer, working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			emit_q    <= 1'b0;
			r_q       <= '0;
		end else begin
			if (out_load_c) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (s_axis_tuser == OP_QUERY)) begin
						off_q   <= in_off;
						len_q   <= in_len;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					rem_q <= off_q;
					r_q   <= '0;
					if (oob_c) begin
						err_q   <= ST_BOUNDS;
						state_q <= S_ERR;
					end else if (cnt_c == '0) begin
						err_q   <= ST_NOCOVER;
						state_q <= S_ERR;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					state_q <= S_WMUL;
				end
				S_WMUL: begin
					ent_first_q <= rd_ent.first;
					ent_last_q  <= rd_ent.last;
					ent_size_q  <= rd_ent.size;
					prod_q      <= prod_c;
					state_q     <= S_WCMP;
				end
				S_WCMP: begin
					if (rem_ge_c) begin
						rem_q <= rem_q - prod_q[OFF_W-1:0];
						if (last_range_c) begin
							err_q   <= ST_NOCOVER;
							state_q <= S_ERR;
						end else begin
							r_q     <= r_q + CW'(1);
							state_q <= S_WRD;
						end
					end else begin
						found_q <= r_q;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						start_idx_q <= ent_first_q + div_quot;
						i_q         <= ent_first_q + div_quot;
						soff_q      <= div_rmd;
						n_q         <= '0;
						prc_q       <= '0;
						emit_q      <= 1'b0;
						state_q     <= S_RUN;
					end
				end
				S_RUN: begin
					if (step_c) begin
						if (full_c) begin
							err_q   <= ST_TOOLONG;
							state_q <= S_ERR;
						end else begin
							n_q   <= n_q + NW'(1);
							prc_q <= prc_nxt_c;
							if (emit_q) begin
								m_user_q  <= ST_OK;
								m_last_q  <= covered_c;
								m_data_q  <= {4'b0, (first_c ? soff_q : SIZE_W'(0)),
									ent_size_q, i_q};
							end
							if (covered_c) begin
								if (emit_q) begin
									emit_q  <= 1'b0;
									state_q <= S_IDLE;
								end else begin
									// Run checked; walk it again and send it.
									emit_q  <= 1'b1;
									r_q     <= found_q;
									state_q <= S_RRD;
								end
							end else if (i_q >= ent_last_q) begin
								if (last_range_c) begin
									err_q   <= ST_NOCOVER;
									state_q <= S_ERR;
								end else begin
									r_q     <= r_q + CW'(1);
									state_q <= S_NRD;
								end
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
						end
					end
				end
				S_NRD: begin
					state_q <= S_NLD;
				end
				S_NLD: begin
					ent_first_q <= rd_ent.first;
					ent_last_q  <= rd_ent.last;
					ent_size_q  <= rd_ent.size;
					i_q         <= rd_ent.first;
					if (!skip_c) begin
						state_q <= S_RUN;
					end else if (last_range_c) begin
						// A reversed range holds no blocks.
						err_q   <= ST_NOCOVER;
						state_q <= S_ERR;
					end else begin
						r_q     <= r_q + CW'(1);
						state_q <= S_NRD;
					end
				end
				S_RRD: begin
					state_q <= S_RLD;
				end
				S_RLD: begin
					ent_first_q <= rd_ent.first;
					ent_last_q  <= rd_ent.last;
					ent_size_q  <= rd_ent.size;
					i_q         <= start_idx_q;
					n_q         <= '0;
					prc_q       <= '0;
					state_q     <= S_RUN;
				end
				S_ERR: begin
					if (out_free) begin
						m_user_q  <= err_q;
						m_last_q  <= 1'b1;
						m_data_q  <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	// Configuration registers; the register is picked by address bit 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize_q       <= '0;
			range_count_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3])
				REG_FSIZE:       fsize_q       <= pwdata[OFF_W-1:0];
				REG_RANGE_COUNT: range_count_q <= pwdata[CNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3])
			REG_FSIZE:       prdata = CFG_DATA_W'(fsize_q);
			REG_RANGE_COUNT: prdata = CFG_DATA_W'(range_count_q);
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;

endmodule
